@@ rtl/encoder_speed_estimator_core_assert.svh @@
// assertion macros of the estimator, used by the sequencer
`ifndef ENCODER_SPEED_ESTIMATOR_CORE_ASSERT_SVH
`define ENCODER_SPEED_ESTIMATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ESP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ESP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/esp_pkg.sv @@
// shared types and constants of the encoder speed estimator
package esp_pkg;

  localparam int MEDIAN_DEPTH = 3;
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = 6;

  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [2:0] REG_BLEND_WEIGHT  = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE      = 3'd2;
  localparam logic [2:0] REG_TIMEOUT       = 3'd3;
  localparam logic [2:0] REG_MIN_RATE      = 3'd4;
  localparam logic [2:0] REG_UM_PER_PULSE  = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PULSE,
    OP_PUSH,
    OP_MED_START,
    OP_MED_STORE,
    OP_WIN_START,
    OP_WIN_STORE,
    OP_EMA_MUL,
    OP_EMA_SUM,
    OP_TMO_START,
    OP_TMO_STORE,
    OP_SPD_START,
    OP_SPD_STORE,
    OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    logic capture;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic window_due;
  } sts_t;

endpackage

@@ rtl/esp_div.sv @@
// restoring divider, one quotient bit per cycle
module esp_div
  import esp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 busy,
  output logic [DIV_NUM_W-1:0] quo
);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // one shift and trial subtract
  always_comb begin
    trial = {rem, quo[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
      cnt   <= DIV_CNT_W'(DIV_NUM_W);
      busy  <= 1'b1;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/esp_ctrl.sv @@
// sequencer of the estimator: steps each item through the datapath
`include "encoder_speed_estimator_core_assert.svh"
module esp_ctrl
  import esp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic kind,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_PULSE, S_PUSH, S_MED_GO, S_MED_WAIT, S_MED_STORE,
    S_WIN_GO, S_WIN_WAIT, S_WIN_STORE, S_EMA_MUL, S_EMA_SUM,
    S_TMO_GO, S_TMO_WAIT, S_TMO_STORE, S_SPD_GO, S_SPD_WAIT,
    S_SPD_STORE, S_FINISH
  } state_t;

  state_t state;
  logic   slot_free;
  logic   out_take;
  logic   div_go;

  assign in_stall  = (state != S_IDLE);
  assign out_take  = out_valid && !out_stall;
  assign slot_free = !out_valid || !out_stall;
  assign div_go    = (cmd.op == OP_MED_START) || (cmd.op == OP_WIN_START);

  // command decode per state
  always_comb begin
    cmd.capture = (state == S_IDLE) && in_valid;
    case (state)
      S_PULSE:     cmd.op = OP_PULSE;
      S_PUSH:      cmd.op = OP_PUSH;
      S_MED_GO:    cmd.op = OP_MED_START;
      S_MED_STORE: cmd.op = OP_MED_STORE;
      S_WIN_GO:    cmd.op = OP_WIN_START;
      S_WIN_STORE: cmd.op = OP_WIN_STORE;
      S_EMA_MUL:   cmd.op = OP_EMA_MUL;
      S_EMA_SUM:   cmd.op = OP_EMA_SUM;
      S_TMO_GO:    cmd.op = OP_TMO_START;
      S_TMO_STORE: cmd.op = OP_TMO_STORE;
      S_SPD_GO:    cmd.op = OP_SPD_START;
      S_SPD_STORE: cmd.op = OP_SPD_STORE;
      S_FINISH:    cmd.op = slot_free ? OP_LOAD_OUT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= kind ? S_PUSH : S_PULSE;
          end
        end
        S_PULSE:     state <= S_IDLE;
        S_PUSH:      state <= S_MED_GO;
        S_MED_GO:    state <= S_MED_WAIT;
        S_MED_WAIT:  if (!sts.div_busy) state <= S_MED_STORE;
        S_MED_STORE: state <= sts.window_due ? S_WIN_GO : S_TMO_GO;
        S_WIN_GO:    state <= S_WIN_WAIT;
        S_WIN_WAIT:  if (!sts.div_busy) state <= S_WIN_STORE;
        S_WIN_STORE: state <= S_EMA_MUL;
        S_EMA_MUL:   state <= S_EMA_SUM;
        S_EMA_SUM:   state <= S_TMO_GO;
        S_TMO_GO:    state <= S_TMO_WAIT;
        S_TMO_WAIT:  if (!sts.div_busy) state <= S_TMO_STORE;
        S_TMO_STORE: state <= S_SPD_GO;
        S_SPD_GO:    state <= S_SPD_WAIT;
        S_SPD_WAIT:  if (!sts.div_busy) state <= S_SPD_STORE;
        S_SPD_STORE: state <= S_FINISH;
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ESP_ASSERT_IMP(a_div_idle_at_start, div_go, !sts.div_busy, "divider started while busy")
  `ESP_ASSERT_IMP(a_load_slot_free, cmd.op == OP_LOAD_OUT, slot_free, "result overwrites a pending item")
  `ESP_ASSERT_NXT(a_out_taken, out_take && cmd.op != OP_LOAD_OUT, !out_valid, "taken item shown again")

endmodule

@@ rtl/esp_dp.sv @@
// datapath of the estimator: registers, ring, median, ema and divider
module esp_dp
  import esp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic [31:0] time_us,
  input  logic [31:0] time_ms,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [23:0] rate_q8,
  output logic [15:0] speed_mm_s,
  output logic        stopped,
  output logic [31:0] pulse_total
);

  localparam logic [DIV_NUM_W-1:0] MED_NUM    = DIV_NUM_W'(256000000);
  localparam logic [17:0]          WIN_SCALE  = 18'd256000;
  // x/1000 is (x*RECIP_1000) >> 38 for 32-bit x, x/125 is (x*RECIP_125) >> 36 for 29-bit x
  localparam logic [28:0]          RECIP_1000 = 29'd274877907;
  localparam logic [29:0]          RECIP_125  = 30'd549755814;

  // configuration
  logic [15:0] sample_period_ms, blend_weight, timeout_ms, um_per_pulse;
  logic [19:0] holdoff_us;
  logic [23:0] min_rate;

  // estimator state
  logic [31:0] time_us_r, time_ms_r;
  logic [31:0] last_pulse_time, latched_interval, pulse_counter;
  logic [31:0] count_snapshot, last_sample_ms;
  logic [31:0] ring [MEDIAN_DEPTH];
  logic [1:0]  ring_slot, ring_fill;
  logic        pulse_seen;
  logic [23:0] filtered_rate, med_rate, chosen;
  logic [15:0] speed;
  logic        stopped_flag;
  logic [39:0] prod_a;
  logic [40:0] prod_b;
  logic [60:0] tmo_scaled;
  logic [39:0] spd_prod;
  logic [58:0] spd_scaled;

  // divider link
  logic                 div_start, div_busy;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;

  logic [31:0] gap, med, dt, delta, elapsed;
  logic [49:0] win_num;
  logic [41:0] ema_sum;
  logic [23:0] quo_sat, ema_sat, rate_tmo;
  logic        timed_out;

  function automatic logic [31:0] mid3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if ((x <= y && y <= z) || (z <= y && y <= x)) return y;
    if ((y <= x && x <= z) || (z <= x && x <= y)) return x;
    return z;
  endfunction

  // combinational helpers
  always_comb begin
    gap       = time_us_r - last_pulse_time;
    med       = (ring_fill >= 2'(MEDIAN_DEPTH)) ? mid3(ring[0], ring[1], ring[2]) : 32'd0;
    dt        = time_ms_r - last_sample_ms;
    delta     = pulse_counter - count_snapshot;
    win_num   = delta * WIN_SCALE;
    quo_sat   = (div_quo[DIV_NUM_W-1:24] != '0) ? 24'hFFFFFF : div_quo[23:0];
    ema_sum   = 42'(prod_a) + 42'(prod_b) + 42'd32768;
    ema_sat   = (ema_sum[41:40] != 2'b00) ? 24'hFFFFFF : ema_sum[39:16];
    elapsed   = time_ms_r - {9'd0, tmo_scaled[60:38]};
    timed_out = elapsed > 32'(timeout_ms);
    rate_tmo  = timed_out ? 24'd0 : filtered_rate;
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = MED_NUM;
    div_den   = med;
    case (cmd.op)
      OP_MED_START: div_start = 1'b1;
      OP_WIN_START: begin
        div_start = 1'b1;
        div_num   = win_num;
        div_den   = dt;
      end
      default: div_start = 1'b0;
    endcase
  end

  esp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (div_quo)
  );

  assign sts.div_busy   = div_busy;
  assign sts.window_due = dt >= 32'(sample_period_ms);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period_ms <= 16'd50;
      blend_weight     <= 16'd19661;
      holdoff_us       <= 20'd200;
      timeout_ms       <= 16'd500;
      min_rate         <= 24'd256;
      um_per_pulse     <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD: sample_period_ms <= cfg_data[15:0];
        REG_BLEND_WEIGHT:  blend_weight     <= cfg_data[15:0];
        REG_DEBOUNCE:      holdoff_us       <= cfg_data[19:0];
        REG_TIMEOUT:       timeout_ms       <= cfg_data[15:0];
        REG_MIN_RATE:      min_rate         <= cfg_data;
        REG_UM_PER_PULSE:  um_per_pulse     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      time_us_r <= time_us;
      time_ms_r <= time_ms;
    end
    // speed is ((rate*um) >> 11) / 125, one multiply stage per cycle
    spd_scaled <= spd_prod[39:11] * RECIP_125;
    case (cmd.op)
      OP_MED_STORE: med_rate <= (med == 32'd0) ? 24'd0 : quo_sat;
      OP_WIN_STORE: chosen <= (delta >= 32'd3) ? ((dt == 32'd0) ? 24'd0 : quo_sat) : med_rate;
      OP_EMA_MUL: begin
        prod_a <= blend_weight * chosen;
        prod_b <= (17'h10000 - 17'(blend_weight)) * filtered_rate;
      end
      OP_TMO_START: tmo_scaled <= last_pulse_time * RECIP_1000;
      OP_SPD_START: spd_prod <= filtered_rate * um_per_pulse;
      OP_SPD_STORE: speed <= (spd_scaled[58:52] != '0) ? 16'hFFFF : spd_scaled[51:36];
      OP_LOAD_OUT: begin
        rate_q8     <= filtered_rate;
        speed_mm_s  <= speed;
        stopped     <= stopped_flag;
        pulse_total <= pulse_counter;
      end
      default: ;
    endcase
  end

  // estimator state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse_time  <= '0;
      latched_interval <= '0;
      pulse_counter    <= '0;
      count_snapshot   <= '0;
      last_sample_ms   <= '0;
      ring[0]          <= '0;
      ring[1]          <= '0;
      ring[2]          <= '0;
      ring_slot        <= '0;
      ring_fill        <= '0;
      pulse_seen       <= 1'b0;
      filtered_rate    <= '0;
      stopped_flag     <= 1'b0;
    end else begin
      case (cmd.op)
        OP_PULSE: begin
          if (!pulse_seen || gap > 32'(holdoff_us)) begin
            latched_interval <= pulse_seen ? gap : 32'd0;
            last_pulse_time  <= time_us_r;
            pulse_counter    <= pulse_counter + 32'd1;
            pulse_seen       <= 1'b1;
          end
        end
        OP_PUSH: begin
          if (latched_interval != 32'd0) begin
            ring[ring_slot] <= latched_interval;
            ring_slot <= (ring_slot == 2'(MEDIAN_DEPTH - 1)) ? 2'd0 : ring_slot + 2'd1;
            if (ring_fill < 2'(MEDIAN_DEPTH)) begin
              ring_fill <= ring_fill + 2'd1;
            end
          end
        end
        OP_EMA_SUM: begin
          filtered_rate  <= ema_sat;
          count_snapshot <= pulse_counter;
          last_sample_ms <= time_ms_r;
        end
        OP_TMO_STORE: begin
          stopped_flag  <= timed_out;
          filtered_rate <= (rate_tmo < min_rate) ? 24'd0 : rate_tmo;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/encoder_speed_estimator_core.sv @@
// top level of the single-wheel encoder speed estimator
// One wheel per instance. An encoder edge item (kind 0) keeps the input stalled
// while its pulse step runs and gives no result; an update item (kind 1)
// gives one result, after extra division steps when the sample window is
// due, and the input stays stalled until then. The time goes to the single
// shared restoring divider, which holds the sequencer while a division runs;
// it runs for the median rate and, when the window is due, for the
// window rate; the millisecond conversion of the last edge time and the speed
// scaling use reciprocal multiplies. A finished result sits in an output
// register, so the next item is taken while it waits; a following update item
// stalls at its end until that result is taken.
module encoder_speed_estimator_core
  import esp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [31:0] time_us,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] rate_q8,
  output logic [15:0] speed_mm_s,
  output logic        stopped,
  output logic [31:0] pulse_total
);

  cmd_t cmd;
  sts_t sts;

  esp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  esp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .time_us    (time_us),
    .time_ms    (time_ms),
    .cmd        (cmd),
    .sts        (sts),
    .rate_q8    (rate_q8),
    .speed_mm_s (speed_mm_s),
    .stopped    (stopped),
    .pulse_total(pulse_total)
  );

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the single-wheel encoder speed estimator
module tb_top;
  import esp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;
  localparam logic [2:0] REG_NO_SUCH = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [31:0] time_us = '0;
  logic [31:0] time_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] rate_q8;
  logic [15:0] speed_mm_s;
  logic        stopped;
  logic [31:0] pulse_total;

  typedef struct packed {
    logic [23:0] rate;
    logic [15:0] speed;
    logic        stop;
    logic [31:0] total;
  } speed_rec_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] us;
    logic [31:0] ms;
    logic        fixed;
    speed_rec_t  want;
  } stim_row_t;

  encoder_speed_estimator_core u_dut (.*);

  always #5 clk = ~clk;

  // estimator state mirrored in the bench
  logic [15:0] p_period, p_alpha, p_timeout, p_um;
  logic [19:0] p_debounce;
  logic [23:0] p_min;
  logic [31:0] s_last_us, s_latched, s_total, s_snap, s_last_ms;
  logic [31:0] s_ring [3];
  int unsigned s_slot, s_fill;
  logic [23:0] s_rate;
  logic        s_stop, s_seen;

  speed_rec_t  expected_q[$];
  int          errors = 0;
  logic        hold_long = 1'b0;
  logic        quiet = 1'b0;
  logic        draining = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task automatic mirror_reset();
    p_period = 50; p_alpha = 19661; p_debounce = 200; p_timeout = 500;
    p_min = 256; p_um = 1000;
    s_last_us = 0; s_latched = 0; s_total = 0; s_snap = 0; s_last_ms = 0;
    s_ring[0] = 0; s_ring[1] = 0; s_ring[2] = 0;
    s_slot = 0; s_fill = 0; s_rate = 0; s_stop = 0; s_seen = 0;
  endtask

  function automatic logic [23:0] clip24(input logic [63:0] v);
    return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
  endfunction

  function automatic logic [31:0] middle(input logic [31:0] x, y, z);
    if ((x <= y && y <= z) || (z <= y && y <= x)) return y;
    if ((y <= x && x <= z) || (z <= x && x <= y)) return x;
    return z;
  endfunction

  // advance the mirror by one item; returns 1 when a result is due
  function automatic logic predict_speed(input logic k, input logic [31:0] us,
                                         input logic [31:0] ms, output speed_rec_t r);
    logic [31:0] gap, med, dt, delta, elapsed;
    logic [23:0] med_rate, win, chosen;
    logic [63:0] blend, spd;
    med = 0; med_rate = 0; r = '0;
    if (k == KIND_EDGE) begin
      gap = us - s_last_us;
      if (!s_seen || gap > p_debounce) begin
        s_latched = s_seen ? gap : 0;
        s_last_us = us;
        s_total++;
        s_seen = 1;
      end
      return 0;
    end
    if (s_latched > 0) begin
      s_ring[s_slot] = s_latched;
      s_slot = (s_slot + 1) % 3;
      if (s_fill < 3) s_fill++;
    end
    if (s_fill >= 3) med = middle(s_ring[0], s_ring[1], s_ring[2]);
    if (med > 0) med_rate = clip24(64'd256000000 / med);
    dt = ms - s_last_ms;
    if (dt >= p_period) begin
      delta = s_total - s_snap;
      win = (dt > 0) ? clip24(64'(delta) * 256000 / dt) : 24'd0;
      chosen = (delta >= 3) ? win : med_rate;
      blend = (64'(p_alpha) * chosen + 64'(65536 - p_alpha) * s_rate + 32768) >> 16;
      s_rate = clip24(blend);
      s_snap = s_total;
      s_last_ms = ms;
    end
    elapsed = ms - s_last_us / 1000;
    if (elapsed > p_timeout) begin
      s_rate = 0; s_stop = 1;
    end else begin
      s_stop = 0;
    end
    if (s_rate < p_min) s_rate = 0;
    spd = 64'(s_rate) * p_um / 256000;
    r.rate = s_rate;
    r.speed = (spd > 64'hFFFF) ? 16'hFFFF : spd[15:0];
    r.stop = s_stop;
    r.total = s_total;
    return 1;
  endfunction

  task automatic send_item(input logic k, input logic [31:0] us, input logic [31:0] ms,
                           input logic fixed, input speed_rec_t want);
    speed_rec_t r;
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; kind <= k; time_us <= us; time_ms <= ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_speed(k, us, ms, r)) begin
      if (fixed && r != want) report("directed row", 32'(r.rate), 32'(want.rate));
      expected_q.push_back(r);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SAMPLE_PERIOD: p_period = val[15:0];
      REG_BLEND_WEIGHT:  p_alpha = val[15:0];
      REG_DEBOUNCE:      p_debounce = val[19:0];
      REG_TIMEOUT:       p_timeout = val[15:0];
      REG_MIN_RATE:      p_min = val;
      REG_UM_PER_PULSE:  p_um = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    speed_rec_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 32'(rate_q8), 32'd0);
      end else begin
        w = expected_q.pop_front();
        if (rate_q8 !== w.rate) report("rate_q8", 32'(rate_q8), 32'(w.rate));
        if (speed_mm_s !== w.speed) report("speed_mm_s", 32'(speed_mm_s), 32'(w.speed));
        if (stopped !== w.stop) report("stopped", 32'(stopped), 32'(w.stop));
        if (pulse_total !== w.total) report("pulse_total", pulse_total, w.total);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (hold_long) out_stall <= 1'b1;
    else if (quiet || draining) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 12);
  end

  // long receiver hold-off
  initial begin
    wait (!rst);
    repeat (4000) @(negedge clk);
    hold_long = 1'b1;
    repeat (3000) @(negedge clk);
    hold_long = 1'b0;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t rows[$];
    logic [31:0] us, ms;
    int n;
    logic k;
    mirror_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: fresh state, first edge, stale interval, timeout, extremes
    rows.push_back('{KIND_UPDATE, 32'd0, 32'd0, 1'b1, '{24'd0, 16'd0, 1'b0, 32'd0}});
    rows.push_back('{KIND_UPDATE, 32'd0, 32'd600, 1'b1, '{24'd0, 16'd0, 1'b1, 32'd0}});
    rows.push_back('{KIND_EDGE, 32'd1000, 32'd1, 1'b0, '0});
    rows.push_back('{KIND_EDGE, 32'd1100, 32'd1, 1'b0, '0});
    rows.push_back('{KIND_EDGE, 32'd2000, 32'd2, 1'b0, '0});
    rows.push_back('{KIND_UPDATE, 32'd2000, 32'd2, 1'b0, '0});
    rows.push_back('{KIND_UPDATE, 32'd2000, 32'd3, 1'b0, '0});
    rows.push_back('{KIND_EDGE, 32'd2001, 32'd3, 1'b0, '0});
    rows.push_back('{KIND_EDGE, 32'd3000, 32'd3, 1'b0, '0});
    rows.push_back('{KIND_UPDATE, 32'd3000, 32'd60, 1'b0, '0});
    rows.push_back('{KIND_EDGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0});
    rows.push_back('{KIND_EDGE, 32'd5, 32'hFFFF_FFFF, 1'b0, '0});
    rows.push_back('{KIND_UPDATE, 32'd5, 32'hFFFF_FFFF, 1'b0, '0});
    rows.push_back('{KIND_UPDATE, 32'hFFFF_FFFF, 32'h0000_0010, 1'b0, '0});
    foreach (rows[i]) send_item(rows[i].kind, rows[i].us, rows[i].ms, rows[i].fixed,
                                rows[i].want);
    wait_idle();
    // extreme settings, tiny sample period
    write_reg(REG_SAMPLE_PERIOD, 24'd0);
    write_reg(REG_BLEND_WEIGHT, 24'd65535);
    write_reg(REG_DEBOUNCE, 24'd0);
    write_reg(REG_TIMEOUT, 24'd65535);
    write_reg(REG_MIN_RATE, 24'd0);
    write_reg(REG_UM_PER_PULSE, 24'd65535);
    write_reg(REG_NO_SUCH, 24'hFFFFFF);
    for (int i = 0; i < 8; i++) send_item(i[0], 32'(i), 32'd100, 1'b0, '0);
    send_item(KIND_UPDATE, 32'd10, 32'd100, 1'b0, '0);
    wait_idle();
    // random phases across several settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_SAMPLE_PERIOD, 24'd1); write_reg(REG_BLEND_WEIGHT, 24'd0);
          write_reg(REG_DEBOUNCE, 24'hFFFFF); write_reg(REG_TIMEOUT, 24'd1);
          write_reg(REG_MIN_RATE, 24'hFFFFFF); write_reg(REG_UM_PER_PULSE, 24'd0);
        end
        1: begin
          write_reg(REG_SAMPLE_PERIOD, 24'd20); write_reg(REG_BLEND_WEIGHT, 24'd30000);
          write_reg(REG_DEBOUNCE, 24'd50); write_reg(REG_TIMEOUT, 24'd400);
          write_reg(REG_MIN_RATE, 24'd100); write_reg(REG_UM_PER_PULSE, 24'd2000);
        end
        2: begin
          write_reg(REG_SAMPLE_PERIOD, 24'd65535); write_reg(REG_BLEND_WEIGHT, 24'd65535);
          write_reg(REG_DEBOUNCE, 24'd0); write_reg(REG_TIMEOUT, 24'd65535);
          write_reg(REG_MIN_RATE, 24'd0); write_reg(REG_UM_PER_PULSE, 24'd65535);
        end
        default: begin
          write_reg(REG_SAMPLE_PERIOD, 24'(1 + $urandom_range(100)));
          write_reg(REG_BLEND_WEIGHT, 24'($urandom_range(65535)));
          write_reg(REG_DEBOUNCE, 24'($urandom_range(500)));
          write_reg(REG_TIMEOUT, 24'(1 + $urandom_range(1000)));
          write_reg(REG_MIN_RATE, 24'($urandom_range(20000)));
          write_reg(REG_UM_PER_PULSE, 24'($urandom_range(65535)));
        end
      endcase
      quiet = (ph == 1);
      us = $urandom; ms = us / 1000;
      n = 0;
      while (n < 200) begin
        if ($urandom_range(9) == 0) begin
          // noise: arbitrary times
          k = 1'($urandom_range(1));
          send_item(k, $urandom, $urandom, 1'b0, '0);
        end else begin
          // plausible motion: edges with realistic gaps, with an update now and then
          us += $urandom_range(4000);
          if ($urandom_range(3) == 0) us += $urandom_range(200000);
          ms = us / 1000;
          k = ($urandom_range(3) == 0) ? KIND_UPDATE : KIND_EDGE;
          send_item(k, us, ms, 1'b0, '0);
        end
        n++;
      end
      send_item(KIND_UPDATE, us, ms, 1'b0, '0);
      wait_idle();
    end
    quiet = 1'b0;
    draining = 1'b1;
    wait_idle();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
